### rtl/core/tac_pkg.sv
// Shared types and constants for the touch auto-calibration normalizer.
// No dependencies; used by the interfaces, the divider and the top level.
package tac_pkg;

  localparam int RAW_W      = 10;  // raw reading and stored limit width
  localparam int POS_W      = 16;  // signed screen coordinate width
  localparam int TOP_W      = 13;  // holds any target maximum (up to 8191)
  localparam int PROD_W     = RAW_W + TOP_W;
  localparam int ROT_W      = POS_W + 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;
  localparam int TURN_W     = 2;
  localparam int Y_OVERSHOOT = 10;

  localparam logic [RAW_W-1:0] X_LOW_RST  = RAW_W'(100);
  localparam logic [RAW_W-1:0] X_HIGH_RST = RAW_W'(900);
  localparam logic [RAW_W-1:0] Y_LOW_RST  = RAW_W'(75);
  localparam logic [RAW_W-1:0] Y_HIGH_RST = RAW_W'(900);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INIT_X_LOW  = 3'd0,
    REG_INIT_X_HIGH = 3'd1,
    REG_INIT_Y_LOW  = 3'd2,
    REG_INIT_Y_HIGH = 3'd3,
    REG_SCREEN_TURN = 3'd4
  } cfg_reg_t;

  typedef enum logic [TURN_W-1:0] {
    TURN_NONE    = 2'd0,
    TURN_QUARTER = 2'd1,
    TURN_HALF    = 2'd2,
    TURN_THREE_Q = 2'd3
  } turn_t;

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [ROT_W-1:0] v);
    logic signed [POS_W-1:0] r;
    if (v > ROT_W'(32767)) begin
      r = 16'sh7FFF;
    end else if (v < -ROT_W'(32768)) begin
      r = 16'sh8000;
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

endpackage

### rtl/core/tac_if.sv
// Valid/ready channels carrying raw touch items in and screen positions out.
// Depends on tac_pkg for field widths.
interface tac_in_if;
  logic                     valid;
  logic                     ready;
  logic [tac_pkg::RAW_W-1:0] raw_x;
  logic [tac_pkg::RAW_W-1:0] raw_y;

  modport source (output valid, output raw_x, output raw_y, input ready);
  modport sink (input valid, input raw_x, input raw_y, output ready);
endinterface

interface tac_out_if;
  logic                            valid;
  logic                            ready;
  logic signed [tac_pkg::POS_W-1:0] pos_x;
  logic signed [tac_pkg::POS_W-1:0] pos_y;
  logic                            limits_changed;

  modport source (output valid, output pos_x, output pos_y, output limits_changed,
                  input ready);
  modport sink (input valid, input pos_x, input pos_y, input limits_changed,
                output ready);
endinterface

### rtl/core/tac_div.sv
// Iterative restoring divider, one quotient bit per cycle (unsigned).
// Depends on tac_pkg for operand widths.
module tac_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [tac_pkg::PROD_W-1:0]  dividend,
  input  logic [tac_pkg::RAW_W-1:0]   divisor,
  output logic                        done,
  output logic [tac_pkg::PROD_W-1:0]  quotient
);
  import tac_pkg::*;

  localparam int CNT_W = $clog2(PROD_W + 1);

  logic [PROD_W-1:0] dvd;
  logic [RAW_W-1:0]  dvs;
  logic [RAW_W-1:0]  rem;
  logic [CNT_W-1:0]  cnt;
  logic              busy;

  logic [RAW_W:0]    rem_sh;
  logic [RAW_W:0]    diff;
  logic              qbit;

  always_comb begin
    rem_sh = {rem, dvd[PROD_W-1]};
    diff   = rem_sh - {1'b0, dvs};
    qbit   = ~diff[RAW_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(PROD_W);
        dvd  <= dividend;
        dvs  <= divisor;
        rem  <= '0;
      end else if (busy) begin
        rem <= qbit ? diff[RAW_W-1:0] : rem_sh[RAW_W-1:0];
        dvd <= {dvd[PROD_W-2:0], qbit};
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = dvd;

endmodule

### rtl/core/touch_autocal_normalizer_top.sv
// Touch auto-calibration normalizer: maps raw touch items to screen positions.
// Depends on tac_pkg, tac_in_if / tac_out_if and tac_div.
//
// Usage:
//   in_ch  carries raw_x / raw_y; an item is taken when valid and ready are high.
//   out_ch carries pos_x / pos_y / limits_changed, one item per input item.
//   cfg_we / cfg_index / cfg_wdata write the registers: 0..3 load the x/y
//   low/high limits, 4 sets the display rotation; other indexes are ignored.
// Timing:
//   The limits are widened in the accept cycle. Each axis then takes a setup
//   step (S_LOAD) and a pass through the shared bit-serial divider (S_DIV) that
//   ends with the quotient picked up; x and y go through the same divider one
//   after the other. S_FIN then rotates and loads the output register. An axis
//   with a zero span skips the divider. in_ch.ready is high only while no item
//   is in work.
// Reset clears the limits to 100/900 (x) and 75/900 (y) and the rotation to none.
// A stalled receiver holds the result in the output register; the next item is
// still taken and worked on, and waits before its final step until it drains.
module touch_autocal_normalizer_top #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 480
) (
  input  logic                           clk,
  input  logic                           rst,
  tac_in_if.sink                         in_ch,
  tac_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [tac_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tac_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import tac_pkg::*;

  localparam logic [TOP_W-1:0] X_TOP = TOP_W'(SCREEN_WIDTH - 1);
  localparam logic [TOP_W-1:0] Y_TOP = TOP_W'(SCREEN_HEIGHT + Y_OVERSHOOT);
  localparam logic signed [POS_W-1:0] Y_MAX = POS_W'(SCREEN_HEIGHT - 1);
  localparam logic signed [ROT_W-1:0] W_LAST = ROT_W'(SCREEN_WIDTH - 1);
  localparam logic signed [ROT_W-1:0] H_LAST = ROT_W'(SCREEN_HEIGHT - 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOAD = 4'b0010,
    S_DIV  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [RAW_W-1:0] x_lo, x_hi, y_lo, y_hi;
  logic [TURN_W-1:0] turn;
  logic [RAW_W-1:0] raw_x, raw_y;
  logic             changed;
  logic             axis;
  logic             neg;
  logic signed [POS_W-1:0] mx, my;

  logic             out_valid;
  logic signed [POS_W-1:0] pos_x, pos_y;
  logic             out_changed;

  logic accept;
  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == S_IDLE);

  // Widening of the limits by the incoming item
  logic [RAW_W-1:0] x_lo_w, x_hi_w, y_lo_w, y_hi_w;
  logic             chg_w;
  always_comb begin
    x_lo_w = x_lo;
    x_hi_w = x_hi;
    y_lo_w = y_lo;
    y_hi_w = y_hi;
    chg_w  = 1'b0;
    if (in_ch.raw_x != '0) begin
      if (in_ch.raw_x < x_lo) begin
        x_lo_w = in_ch.raw_x;
        chg_w  = 1'b1;
      end
      if (in_ch.raw_x > x_hi) begin
        x_hi_w = in_ch.raw_x;
        chg_w  = 1'b1;
      end
    end
    if (in_ch.raw_y != '0) begin
      if (in_ch.raw_y < y_lo) begin
        y_lo_w = in_ch.raw_y;
        chg_w  = 1'b1;
      end
      if (in_ch.raw_y > y_hi) begin
        y_hi_w = in_ch.raw_y;
        chg_w  = 1'b1;
      end
    end
  end

  // Operand setup for the current axis: |raw - lo| * top over |hi - lo|
  logic [RAW_W-1:0]  sel_raw, sel_lo, sel_hi;
  logic [TOP_W-1:0]  sel_top;
  logic [RAW_W:0]    num, span, num_mag, span_mag;
  logic [PROD_W-1:0] product;
  logic              span_zero;
  always_comb begin
    sel_raw  = axis ? raw_y : raw_x;
    sel_lo   = axis ? y_lo : x_lo;
    sel_hi   = axis ? y_hi : x_hi;
    sel_top  = axis ? Y_TOP : X_TOP;
    num      = {1'b0, sel_raw} - {1'b0, sel_lo};
    span     = {1'b0, sel_hi} - {1'b0, sel_lo};
    num_mag  = num[RAW_W] ? -num : num;
    span_mag = span[RAW_W] ? -span : span;
    span_zero = (span == '0);
    product  = PROD_W'(num_mag[RAW_W-1:0]) * PROD_W'(sel_top);
  end

  logic              div_start;
  logic              div_done;
  logic [PROD_W-1:0] quotient;
  assign div_start = (state == S_LOAD) && !span_zero;

  tac_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (product),
    .divisor  (span_mag[RAW_W-1:0]),
    .done     (div_done),
    .quotient (quotient)
  );

  // Signed, saturated axis value from the quotient magnitude
  logic signed [POS_W-1:0] axis_val;
  always_comb begin
    if (!neg) begin
      axis_val = (quotient > PROD_W'(32767)) ? 16'sh7FFF : quotient[POS_W-1:0];
    end else begin
      axis_val = (quotient > PROD_W'(32768)) ? 16'sh8000 : -quotient[POS_W-1:0];
    end
  end

  // Clamp and rotation
  logic signed [POS_W-1:0] my_c;
  logic signed [ROT_W-1:0] ex, ey, rot_x, rot_y;
  logic                    fin_go;
  always_comb begin
    my_c = (my > Y_MAX) ? Y_MAX : my;
    ex   = ROT_W'(mx);
    ey   = ROT_W'(my_c);
    unique case (turn_t'(turn))
      TURN_QUARTER: begin
        rot_x = ey;
        rot_y = W_LAST - ex;
      end
      TURN_HALF: begin
        rot_x = W_LAST - ex;
        rot_y = H_LAST - ey;
      end
      TURN_THREE_Q: begin
        rot_x = H_LAST - ey;
        rot_y = ex;
      end
      default: begin
        rot_x = ex;
        rot_y = ey;
      end
    endcase
    fin_go = !out_valid || out_ch.ready;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) state_next = S_LOAD;
      S_LOAD: if (span_zero) state_next = axis ? S_FIN : S_LOAD;
              else state_next = S_DIV;
      S_DIV:  if (div_done) state_next = axis ? S_FIN : S_LOAD;
      S_FIN:  if (fin_go) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      x_lo      <= X_LOW_RST;
      x_hi      <= X_HIGH_RST;
      y_lo      <= Y_LOW_RST;
      y_hi      <= Y_HIGH_RST;
      turn      <= TURN_W'(TURN_NONE);
      axis      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_INIT_X_LOW:  x_lo <= cfg_wdata[RAW_W-1:0];
          REG_INIT_X_HIGH: x_hi <= cfg_wdata[RAW_W-1:0];
          REG_INIT_Y_LOW:  y_lo <= cfg_wdata[RAW_W-1:0];
          REG_INIT_Y_HIGH: y_hi <= cfg_wdata[RAW_W-1:0];
          REG_SCREEN_TURN: turn <= cfg_wdata[TURN_W-1:0];
          default: ;
        endcase
      end else if (accept) begin
        x_lo <= x_lo_w;
        x_hi <= x_hi_w;
        y_lo <= y_lo_w;
        y_hi <= y_hi_w;
      end

      if (accept) begin
        axis <= 1'b0;
      end else if ((state == S_LOAD && span_zero) || (state == S_DIV && div_done)) begin
        axis <= 1'b1;
      end

      if (state == S_FIN && fin_go) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      raw_x   <= in_ch.raw_x;
      raw_y   <= in_ch.raw_y;
      changed <= chg_w;
    end
    if (state == S_LOAD) begin
      neg <= num[RAW_W] ^ span[RAW_W];
      if (span_zero) begin
        if (axis) my <= '0;
        else mx <= '0;
      end
    end
    if (state == S_DIV && div_done) begin
      if (axis) my <= axis_val;
      else mx <= axis_val;
    end
    if (state == S_FIN && fin_go) begin
      pos_x       <= sat_pos(rot_x);
      pos_y       <= sat_pos(rot_y);
      out_changed <= changed;
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.pos_x          = pos_x;
  assign out_ch.pos_y          = pos_y;
  assign out_ch.limits_changed = out_changed;

endmodule
